FILE: design/isort_pkg.sv
// isort_pkg: shared types for the insertion sorter.
// No dependencies; imported by isort_cell and insertion_sorter.
package isort_pkg;

    // Controller phase: loading words or draining the sorted run
    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast word this cycle
        logic shift;  // move every word one cell toward the head
    } t_cell_ctl;

endpackage

FILE: design/isort_cell.sv
// isort_cell: one slot of the insertion chain.
// Depends on isort_pkg (t_cell_ctl).
module isort_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CAPACITY   = 32,
    parameter int IDX        = 0
) (
    input  logic                                 i_clk,
    input  isort_pkg::t_cell_ctl                 i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_fill,
    input  logic signed [VALUE_BITS-1:0]         i_value,
    input  logic signed [VALUE_BITS-1:0]         i_prev_value,
    input  logic                                 i_prev_take,
    input  logic signed [VALUE_BITS-1:0]         i_next_value,
    output logic signed [VALUE_BITS-1:0]         o_value,
    output logic                                 o_take
);
    import isort_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_BITS-1:0] r_value;
    logic                         w_occ;

    // slot holds a word when its index is below the fill count
    assign w_occ = (CW'(IDX) < i_fill);
    // empty slots act as +infinity; only strictly greater words move up
    assign o_take  = !w_occ || (r_value > i_value);
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && o_take) begin
            r_value <= i_prev_take ? i_prev_value : i_value;
        end else if (i_ctl.shift) begin
            r_value <= i_next_value;
        end
    end

endmodule

FILE: design/insertion_sorter.sv
// insertion_sorter: top level, a stable insertion sorter built as a cell chain.
// Depends on isort_pkg and isort_cell.
//
// Usage: present a signed word on i_value with start high; it is taken at any
// edge where busy is low, one word per clock while loading. Every cell compares
// the broadcast word against its own content in the same cycle, and each
// strictly greater word steps one cell up, so the chain stays sorted and equal
// words keep arrival order. A word arriving with i_last_in high is inserted
// too, then the run drains from the head of the chain, one result per clock
// on o_valid, lowest first, with o_last_out on the final one. Busy is high
// for the whole drain of a run (a run holds at least one word), while the
// chain shifts toward the head. The receiver cannot stall: each result is on the
// output ports for exactly one cycle. Words that arrive while all CAPACITY
// cells are full are dropped and o_overflow is high on every result of that
// run. After the drain the chain is empty and the flag is clear.
module insertion_sorter #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic                          i_last_in,
    output logic                          busy,
    output logic                          o_valid,
    output logic signed [VALUE_BITS-1:0]  o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflow
);
    import isort_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill,  n_fill;
    logic           r_dropped, n_dropped;

    t_cell_ctl      w_ctl;
    logic           w_accept;
    logic           w_full;

    logic signed [VALUE_BITS-1:0] w_value [CAPACITY];
    logic                         w_take  [CAPACITY];

    assign w_accept = start && (r_state == ST_LOAD);
    assign w_full   = (r_fill == CW'(CAPACITY));

    // ---------------- cell chain ----------------
    // Cell k takes its lower neighbor's word when that neighbor also moves,
    // else the new word; on a drain it takes its upper neighbor's word.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [VALUE_BITS-1:0] w_prev_value;
        logic                         w_prev_take;
        logic signed [VALUE_BITS-1:0] w_next_value;

        if (k == 0) begin : g_head
            assign w_prev_value = i_value;
            assign w_prev_take  = 1'b0;
        end else begin : g_body
            assign w_prev_value = w_value[k-1];
            assign w_prev_take  = w_take[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign w_next_value = '0;
        end else begin : g_mid
            assign w_next_value = w_value[k+1];
        end

        isort_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CAPACITY   (CAPACITY),
            .IDX        (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_fill       (r_fill),
            .i_value      (i_value),
            .i_prev_value (w_prev_value),
            .i_prev_take  (w_prev_take),
            .i_next_value (w_next_value),
            .o_value      (w_value[k]),
            .o_take       (w_take[k])
        );
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                    if (i_last_in) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_fill = r_fill - CW'(1);
                if (r_fill == CW'(1)) begin
                    n_state   = ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        w_ctl       = '0;
        busy        = 1'b0;
        o_valid     = 1'b0;
        o_last_out  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                w_ctl.ins = w_accept && !w_full;
            end
            ST_DRAIN: begin
                w_ctl.shift = 1'b1;
                busy        = 1'b1;
                o_valid     = 1'b1;
                o_last_out  = (r_fill == CW'(1));
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign o_sorted_value = w_value[0];
    assign o_overflow     = r_dropped;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
        end
    end

endmodule

FILE: design/isort_checker.sv
// isort_checker: port-level assertions for insertion_sorter, plus its bind.
// Depends on insertion_sorter's port list only.
module isort_checker #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          i_last_in,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic signed [VALUE_BITS-1:0]  o_sorted_value,
    input  logic                          o_last_out,
    input  logic                          o_overflow
);

    // a final word always yields a run starting next cycle
    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_in |=> o_valid)
        else $error("no result after final word");

    // a run is contiguous until its marked end
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_out |=> o_valid)
        else $error("gap inside sorted run");

    // the marked end closes the run
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_out |=> !o_valid)
        else $error("result after end of run");

    // results come out in ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_out |=> o_sorted_value >= $past(o_sorted_value))
        else $error("run not ascending");

    // overflow flag is constant over a run
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_out |=> o_overflow == $past(o_overflow))
        else $error("overflow changed within run");

endmodule

bind insertion_sorter isort_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_isort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .i_last_in      (i_last_in),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_sorted_value (o_sorted_value),
    .o_last_out     (o_last_out),
    .o_overflow     (o_overflow)
);

FILE: verif/insertion_sorter_tb.sv
// insertion_sorter_tb: self-checking bench for the stable insertion sorter.
// Drives words through the start/busy handshake, predicts each sorted run in a
// local model of the store and checks every drained word. Needs insertion_sorter.
module insertion_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int CLK_HALF      = 6;      // 12 ns clock
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_WORDS  = 460;
    localparam int DRAIN_SETTLE  = CAPACITY + 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Sender idle rates per random phase (percent of cycles)
    localparam int IDLE_LIGHT = 7;
    localparam int IDLE_HEAVY = 55;
    localparam int IDLE_NONE  = 0;

    typedef logic signed [VALUE_BITS-1:0] t_word;

    localparam t_word W_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_word W_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // One drained word as the block presents it
    typedef struct packed {
        t_word value;
        logic  last;
        logic  overflow;
    } t_sorted_word;

    // Directed stimulus row; pinned rows carry their result typed in
    typedef struct packed {
        t_word value;
        logic  last;
        logic  pinned;
        t_word pin_value;
    } t_stim_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_word i_value;
    logic  i_last_in;
    logic  busy;
    logic  o_valid;
    t_word o_sorted_value;
    logic  o_last_out;
    logic  o_overflow;

    insertion_sorter #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    // Directed part. Single-word runs from an empty store come straight back,
    // so their result is typed in; longer runs go through the predictor.
    localparam int DIRECTED_ROWS = 19;
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // right after reset: one zero word
        '{t_word'(0),  1'b1, 1'b1, t_word'(0)},
        // extremes, each alone
        '{W_MIN,       1'b1, 1'b1, W_MIN},
        '{W_MAX,       1'b1, 1'b1, W_MAX},
        // mixed run: duplicates, both extremes, sign crossing
        '{t_word'(7),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(-3), 1'b0, 1'b0, t_word'(0)},
        '{t_word'(7),  1'b0, 1'b0, t_word'(0)},
        '{W_MAX,       1'b0, 1'b0, t_word'(0)},
        '{W_MIN,       1'b0, 1'b0, t_word'(0)},
        '{t_word'(0),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(-1), 1'b0, 1'b0, t_word'(0)},
        '{t_word'(7),  1'b1, 1'b0, t_word'(0)},
        // descending: every insert walks to the head
        '{t_word'(3),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(2),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(1),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(0),  1'b1, 1'b0, t_word'(0)},
        // ascending: every insert lands at the tail
        '{t_word'(1),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(2),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(3),  1'b0, 1'b0, t_word'(0)},
        '{t_word'(4),  1'b1, 1'b0, t_word'(0)}
    };

    // Predictor state: sorted store, fill level and dropped flag
    t_word        sorted_store [CAPACITY];
    int           fill_count;
    logic         store_dropped;
    t_sorted_word drain_buf [CAPACITY];

    // Sorted words still owed by the block, oldest first
    t_sorted_word pending_words [$];

    int idle_pct;
    int mismatches;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Insert one word into the predicted store; on a last word, copy the
    // whole run into drain_buf, empty the store and return the run length.
    function automatic int insert_and_drain(input t_word v, input logic last);
        int pos;
        int n;
        int k;
        if (fill_count >= CAPACITY) begin
            store_dropped = 1'b1;           // store full: word is lost
        end else begin
            pos = fill_count;
            // only strictly greater words move up, so equal words stay in order
            while (pos > 0 && sorted_store[pos-1] > v) begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = v;
            fill_count++;
        end
        if (!last)
            return 0;
        n = fill_count;
        for (k = 0; k < n; k++)
            drain_buf[k] = t_sorted_word'{sorted_store[k], k == n - 1, store_dropped};
        fill_count    = 0;
        store_dropped = 1'b0;
        return n;
    endfunction

    function automatic t_word pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return W_MIN;
        if (r == 1)
            return W_MAX;
        if (r <= 4)
            return t_word'($urandom_range(8)) - t_word'(4);  // dense, many ties
        return t_word'($urandom);
    endfunction

    // Mostly short runs; some fill the store exactly, some run past it
    function automatic int pick_run_len();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return CAPACITY;
        if (r < 12)
            return CAPACITY - 1;
        if (r < 20)
            return $urandom_range(CAPACITY + 8, CAPACITY + 1);
        return $urandom_range(12, 1);
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        $display("MISMATCH @%0t %s: got %0d want %0d", $time, what, got, want);
    endtask

    // Present one word, hold it until taken, then book its expected results.
    // busy read right after the edge is the value the block had at that edge.
    task automatic send_word(input t_word v, input logic last, input logic pinned,
                             input t_word pin_value);
        int n;
        int k;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        n = insert_and_drain(v, last);
        if (pinned) begin
            pending_words.push_back(t_sorted_word'{pin_value, 1'b1, 1'b0});
        end else begin
            for (k = 0; k < n; k++)
                pending_words.push_back(drain_buf[k]);
        end
    endtask

    // Output checker: every strobed word must match the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_sorted_word want;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                report_mismatch("sorted word with none pending", o_sorted_value, '0);
            end else begin
                want = pending_words.pop_front();
                if (o_sorted_value !== want.value)
                    report_mismatch("sorted_value", o_sorted_value, want.value);
                if (o_last_out !== want.last)
                    report_mismatch("last_out", t_word'(o_last_out), t_word'(want.last));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", t_word'(o_overflow), t_word'(want.overflow));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        int phase;
        int run_len;
        int k;
        int r;
        start         = 1'b0;
        i_value       = '0;
        i_last_in     = 1'b0;
        i_rst_n       = 1'b0;
        fill_count    = 0;
        store_dropped = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        idle_pct      = IDLE_LIGHT;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
            send_word(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].pin_value);

        // Random runs in three phases: light idling, heavy idling, back to back.
        // Runs always close with a last word so every phase drains fully.
        sent = 0;
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? IDLE_LIGHT : (phase == 1) ? IDLE_HEAVY : IDLE_NONE;
            while (sent < (phase + 1) * RANDOM_WORDS / 3) begin
                run_len = pick_run_len();
                for (k = 0; k < run_len; k++)
                    send_word(pick_value(), k == run_len - 1, 1'b0, '0);
                sent += run_len;
            end
        end
        start <= 1'b0;

        // Let the last run drain, then keep watching the output for stray words
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
design/isort_pkg.sv
design/isort_cell.sv
design/insertion_sorter.sv
design/isort_checker.sv
verif/insertion_sorter_tb.sv
